// File: sv/telrx_pkg.sv
// telrx_pkg: shared types and constants for the telnet receive negotiator.
// No dependencies; used by the step decoder, the top level and the testbench.

package telrx_pkg;

  // Telnet command codes
  localparam logic [7:0] C_IAC  = 8'd255;
  localparam logic [7:0] C_DONT = 8'd254;
  localparam logic [7:0] C_DO   = 8'd253;
  localparam logic [7:0] C_WONT = 8'd252;
  localparam logic [7:0] C_WILL = 8'd251;
  localparam logic [7:0] C_SB   = 8'd250;
  localparam logic [7:0] C_EL   = 8'd248;
  localparam logic [7:0] C_EC   = 8'd247;
  localparam logic [7:0] C_AYT  = 8'd246;
  localparam logic [7:0] C_IP   = 8'd244;
  localparam logic [7:0] C_BRK  = 8'd243;
  localparam logic [7:0] C_SE   = 8'd240;

  // Option codes
  localparam logic [7:0] OPT_BIN  = 8'd0;
  localparam logic [7:0] OPT_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA  = 8'd3;

  // Character constants
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Reset values of the control characters
  localparam logic [7:0] ERASE_RST = 8'd35;
  localparam logic [7:0] KILL_RST  = 8'd64;
  localparam logic [7:0] INTR_RST  = 8'd127;

  // Result port codes
  localparam logic PORT_TERM = 1'b0;
  localparam logic PORT_NET  = 1'b1;

  // Up to three words per network byte
  localparam int MAX_RES = 3;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  typedef enum logic [1:0] {
    CFG_ERASE = 2'd0,
    CFG_KILL  = 2'd1,
    CFG_INTR  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_DATA = 4'd0,
    ST_IAC  = 4'd1,
    ST_CR   = 4'd2,
    ST_SUB  = 4'd3,
    ST_SUBI = 4'd4,
    ST_WILL = 4'd5,
    ST_WONT = 4'd6,
    ST_DO   = 4'd7,
    ST_DONT = 4'd8
  } parse_st_t;

  // Only BINARY, ECHO and SGA can ever be turned on, so those are the
  // only option flags kept.
  typedef struct packed {
    logic sga;
    logic echo;
    logic bin;
  } opt_t;

  typedef struct packed {
    parse_st_t st;
    logic      raw;
    logic      echo;
    opt_t      rem;
    opt_t      loc;
  } telrx_state_t;

  typedef struct packed {
    logic [7:0] erase_c;
    logic [7:0] kill_c;
    logic [7:0] intr_c;
  } telrx_cfg_t;

  typedef struct packed {
    logic       port;
    logic [7:0] data;
  } telrx_res_t;

endpackage

// File: sv/telrx_if.sv
// telrx_if: valid/ready channels of the telnet receive negotiator.
// Depends on nothing; one interface per channel.

interface telrx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] net_byte;
  modport source (output valid, output net_byte, input ready);
  modport sink   (input valid, input net_byte, output ready);
endinterface

interface telrx_out_if;
  logic       valid;
  logic       ready;
  logic       out_port;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       raw_mode;
  logic       echo_crmod;
  modport source (output valid, output out_port, output out_byte, output last_of_run,
                  output raw_mode, output echo_crmod, input ready);
  modport sink   (input valid, input out_port, input out_byte, input last_of_run,
                  input raw_mode, input echo_crmod, output ready);
endinterface

interface telrx_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] idx;
  logic [7:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

// File: sv/telrx_decode.sv
// telrx_decode: one step of the telnet receive machine, combinational.
// Depends on telrx_pkg; instantiated by telnet_receive_negotiator_unit.

module telrx_decode (
  input  telrx_pkg::telrx_state_t               cur,
  input  telrx_pkg::telrx_cfg_t                 cfg,
  input  logic [7:0]                            c,
  output telrx_pkg::telrx_state_t               nxt,
  output logic [telrx_pkg::CNT_W-1:0]           res_cnt,
  output telrx_pkg::telrx_res_t [telrx_pkg::MAX_RES-1:0] res
);

  localparam int CNT_W = telrx_pkg::CNT_W;

  logic known;
  logic rem_on;
  logic loc_on;

  function automatic logic opt_get(telrx_pkg::opt_t t, logic [7:0] code);
    logic v;
    v = 1'b0;
    case (code)
      telrx_pkg::OPT_BIN:  v = t.bin;
      telrx_pkg::OPT_ECHO: v = t.echo;
      telrx_pkg::OPT_SGA:  v = t.sga;
      default:             v = 1'b0;
    endcase
    return v;
  endfunction

  function automatic telrx_pkg::opt_t opt_put(telrx_pkg::opt_t t, logic [7:0] code,
                                              logic v);
    telrx_pkg::opt_t r;
    r = t;
    case (code)
      telrx_pkg::OPT_BIN:  r.bin  = v;
      telrx_pkg::OPT_ECHO: r.echo = v;
      telrx_pkg::OPT_SGA:  r.sga  = v;
      default:             r      = t;
    endcase
    return r;
  endfunction

  assign known  = (c == telrx_pkg::OPT_BIN) || (c == telrx_pkg::OPT_ECHO) ||
                  (c == telrx_pkg::OPT_SGA);
  assign rem_on = opt_get(cur.rem, c);
  assign loc_on = opt_get(cur.loc, c);

  always_comb begin
    nxt     = cur;
    nxt.st  = telrx_pkg::ST_DATA;
    res_cnt = '0;
    for (int i = 0; i < telrx_pkg::MAX_RES; i++) begin
      res[i].port = telrx_pkg::PORT_TERM;
      res[i].data = c;
    end
    // three-word reply layout: IAC, verb, option
    res[0].data = telrx_pkg::C_IAC;

    case (cur.st)
      telrx_pkg::ST_IAC: begin
        res[0].port = telrx_pkg::PORT_TERM;
        if (c == telrx_pkg::C_BRK || c == telrx_pkg::C_IP) begin
          res_cnt     = CNT_W'(1);
          res[0].data = cur.raw ? telrx_pkg::CH_NUL : cfg.intr_c;
        end else if (c == telrx_pkg::C_AYT) begin
          res_cnt     = CNT_W'(1);
          res[0].data = telrx_pkg::CH_BEL;
        end else if (c == telrx_pkg::C_EC) begin
          res_cnt     = CNT_W'(1);
          res[0].data = cfg.erase_c;
        end else if (c == telrx_pkg::C_EL) begin
          res_cnt     = CNT_W'(1);
          res[0].data = cfg.kill_c;
        end else if (c == telrx_pkg::C_SB) begin
          nxt.st = telrx_pkg::ST_SUB;
        end else if (c == telrx_pkg::C_WILL) begin
          nxt.st = telrx_pkg::ST_WILL;
        end else if (c == telrx_pkg::C_WONT) begin
          nxt.st = telrx_pkg::ST_WONT;
        end else if (c == telrx_pkg::C_DO) begin
          nxt.st = telrx_pkg::ST_DO;
        end else if (c == telrx_pkg::C_DONT) begin
          nxt.st = telrx_pkg::ST_DONT;
        end else if (c == telrx_pkg::C_IAC) begin
          res_cnt     = CNT_W'(1);
          res[0].data = c;
        end
      end
      telrx_pkg::ST_CR: begin
        if (c != telrx_pkg::CH_NUL && c != telrx_pkg::CH_LF) begin
          res_cnt     = CNT_W'(1);
          res[0].data = c;
        end
      end
      telrx_pkg::ST_SUB: begin
        nxt.st = (c == telrx_pkg::C_IAC) ? telrx_pkg::ST_SUBI : telrx_pkg::ST_SUB;
      end
      telrx_pkg::ST_SUBI: begin
        nxt.st = (c == telrx_pkg::C_SE) ? telrx_pkg::ST_DATA : telrx_pkg::ST_SUB;
      end
      telrx_pkg::ST_WILL: begin
        if (!rem_on) begin
          res_cnt = CNT_W'(telrx_pkg::MAX_RES);
          if (known) begin
            if (c == telrx_pkg::OPT_BIN)  nxt.raw  = 1'b1;
            if (c == telrx_pkg::OPT_ECHO) nxt.echo = 1'b0;
            nxt.rem     = opt_put(cur.rem, c, 1'b1);
            res[1].data = telrx_pkg::C_DO;
          end else begin
            res[1].data = telrx_pkg::C_DONT;
          end
        end
      end
      telrx_pkg::ST_WONT: begin
        if (rem_on) begin
          res_cnt = CNT_W'(telrx_pkg::MAX_RES);
          if (c == telrx_pkg::OPT_ECHO) nxt.echo = 1'b1;
          if (c == telrx_pkg::OPT_BIN)  nxt.raw  = 1'b0;
          nxt.rem     = opt_put(cur.rem, c, 1'b0);
          res[1].data = telrx_pkg::C_DONT;
        end
      end
      telrx_pkg::ST_DO: begin
        if (!loc_on) begin
          res_cnt = CNT_W'(telrx_pkg::MAX_RES);
          if (known) begin
            if (c == telrx_pkg::OPT_ECHO) nxt.echo = 1'b1;
            if (c == telrx_pkg::OPT_BIN)  nxt.raw  = 1'b1;
            nxt.loc     = opt_put(cur.loc, c, 1'b1);
            res[1].data = telrx_pkg::C_WILL;
          end else begin
            res[1].data = telrx_pkg::C_WONT;
          end
        end
      end
      telrx_pkg::ST_DONT: begin
        if (loc_on) begin
          res_cnt     = CNT_W'(telrx_pkg::MAX_RES);
          nxt.loc     = opt_put(cur.loc, c, 1'b0);
          res[1].data = telrx_pkg::C_WONT;
        end
      end
      default: begin
        // data state, also any unused code
        if (c == telrx_pkg::C_IAC) begin
          nxt.st = telrx_pkg::ST_IAC;
        end else begin
          res_cnt     = CNT_W'(1);
          res[0].data = c;
          if (!cur.loc.bin && c == telrx_pkg::CH_CR) nxt.st = telrx_pkg::ST_CR;
        end
      end
    endcase

    // replies go out on the network side
    if (res_cnt == CNT_W'(telrx_pkg::MAX_RES)) begin
      for (int i = 0; i < telrx_pkg::MAX_RES; i++) res[i].port = telrx_pkg::PORT_NET;
    end
  end

endmodule

// File: sv/telnet_receive_negotiator_unit.sv
// telnet_receive_negotiator_unit: top level of the server-side telnet receiver.
// Depends on telrx_pkg, telrx_if.sv and telrx_decode.
//
//  channel | dir | payload                                           | accepted when
//  in_ch   | in  | net_byte[7:0]                                     | valid && ready
//  out_ch  | out | out_port, out_byte[7:0], last_of_run, raw_mode,   | valid && ready
//          |     | echo_crmod                                        |
//  cfg_ch  | in  | idx[1:0] (0 erase, 1 kill, 2 intr), data[7:0]     | valid && ready
//
// A network byte is decoded in the cycle it is accepted; its words (zero to
// three) land in a three-slot result buffer and show on out_ch the next cycle.
// Ordinary data flows at one byte per cycle while out_ch is not stalled; a
// three-word option reply holds in_ch off while the buffer drains.
// in_ch.ready is high when the buffer is empty or its last word leaves now.
// Reset (rst_n low, synchronous) returns to the data state with only the local
// ECHO option on, echo mode on and raw mode off. cfg_ch is always ready.

module telnet_receive_negotiator_unit (
  input  logic               clk,
  input  logic               rst_n,
  telrx_in_if.sink           in_ch,
  telrx_out_if.source        out_ch,
  telrx_cfg_if.sink          cfg_ch
);

  localparam int CNT_W   = telrx_pkg::CNT_W;
  localparam int MAX_RES = telrx_pkg::MAX_RES;

  // Protocol state and control characters
  telrx_pkg::telrx_state_t st_r;
  telrx_pkg::telrx_state_t st_nxt;
  telrx_pkg::telrx_cfg_t   cfg_r;

  // Result buffer: slot 0 is the head word
  telrx_pkg::telrx_res_t [MAX_RES-1:0] buf_r;
  telrx_pkg::telrx_res_t [MAX_RES-1:0] buf_nxt;
  logic [CNT_W-1:0]                    cnt_r;
  logic [CNT_W-1:0]                    cnt_nxt;

  telrx_pkg::telrx_res_t [MAX_RES-1:0] dec_res;
  logic [CNT_W-1:0]                    dec_cnt;

  logic in_fire;
  logic out_fire;

  telrx_decode u_decode (
    .cur     (st_r),
    .cfg     (cfg_r),
    .c       (in_ch.net_byte),
    .nxt     (st_nxt),
    .res_cnt (dec_cnt),
    .res     (dec_res)
  );

  assign out_fire     = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Buffer control: a new byte only enters once the buffer is (or goes) empty,
  // so a load never overlaps words still waiting.
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (in_fire) begin
      buf_nxt = dec_res;
      cnt_nxt = dec_cnt;
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RES - 1; i++) buf_nxt[i] = buf_r[i+1];
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.st   <= telrx_pkg::ST_DATA;
      st_r.raw  <= 1'b0;
      st_r.echo <= 1'b1;
      st_r.rem  <= '0;
      st_r.loc  <= '{sga: 1'b0, echo: 1'b1, bin: 1'b0};
      cnt_r     <= '0;
    end else begin
      if (in_fire) st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.erase_c <= telrx_pkg::ERASE_RST;
      cfg_r.kill_c  <= telrx_pkg::KILL_RST;
      cfg_r.intr_c  <= telrx_pkg::INTR_RST;
    end else if (cfg_ch.valid) begin
      case (telrx_pkg::cfg_idx_t'(cfg_ch.idx))
        telrx_pkg::CFG_ERASE: cfg_r.erase_c <= cfg_ch.data;
        telrx_pkg::CFG_KILL:  cfg_r.kill_c  <= cfg_ch.data;
        telrx_pkg::CFG_INTR:  cfg_r.intr_c  <= cfg_ch.data;
        default:              cfg_r         <= cfg_r;
      endcase
    end
  end

  // The mode flags only change when a byte is taken, and a byte is taken only
  // as the buffer empties, so the live flags always belong to the buffered words.
  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.out_port    = buf_r[0].port;
  assign out_ch.out_byte    = buf_r[0].data;
  assign out_ch.last_of_run = (cnt_r == CNT_W'(1));
  assign out_ch.raw_mode    = st_r.raw;
  assign out_ch.echo_crmod  = st_r.echo;

endmodule

// File: sv/telrx_checker.sv
// telrx_checker: port-level assertions for telnet_receive_negotiator_unit.
// Depends on nothing but the top level's ports; attached by bind below.

module telrx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_port,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // A stalled word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_port))
    else $error("result word changed while stalled");

  // Input only stalls while words are waiting
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with nothing to deliver");

  // Terminal-side words are always single
  a_term_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_port |-> last_of_run)
    else $error("terminal word not last of its run");

  // The rest of a reply is already buffered
  a_reply_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_run |=> out_valid && out_port)
    else $error("reply run broken");

endmodule

bind telnet_receive_negotiator_unit telrx_checker u_telrx_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_port    (out_ch.out_port),
  .out_byte    (out_ch.out_byte),
  .last_of_run (out_ch.last_of_run)
);

// File: test/testbench.sv
// testbench: self-checking bench for telnet_receive_negotiator_unit.
// Streams network bytes in, predicts every terminal and reply word, and checks
// them in order. Depends on telrx_pkg, the telrx_*_if interfaces and the RTL.

module testbench;
  import telrx_pkg::*;

  localparam int CLK_PERIOD = 8;

  // Commands the block takes but ignores
  localparam logic [7:0] CMD_NOP = 8'd241;
  localparam logic [7:0] CMD_DM  = 8'd242;
  localparam logic [7:0] CMD_AO  = 8'd245;
  localparam logic [7:0] CMD_GA  = 8'd249;

  // One word as seen on out_ch
  typedef struct packed {
    logic       port;
    logic [7:0] data;
    logic       last;
    logic       raw;
    logic       echo;
  } tel_word_t;

  logic clk = 1'b0;
  logic rst_n;

  telrx_in_if  in_ch ();
  telrx_out_if out_ch ();
  telrx_cfg_if cfg_ch ();

  telnet_receive_negotiator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Bytes still to be sent, words still owed by the block
  logic [7:0] net_bytes_pending[$];
  tel_word_t  expected_words[$];
  // Words produced by the byte being decoded right now
  tel_word_t  step_words[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Shadow copy of the receiver: parser state, option tables, modes, registers
  parse_st_t  rx_state;
  logic       remote_on[256];
  logic       local_on[256];
  logic       raw_q;
  logic       echo_q;
  logic [7:0] erase_c;
  logic [7:0] kill_c;
  logic [7:0] intr_c;

  tel_word_t got_word;
  tel_word_t want_word;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic void emit_word(input logic port, input logic [7:0] b);
    tel_word_t w;
    w = '0;
    w.port = port;
    w.data = b;
    step_words.push_back(w);
  endfunction

  // Three-byte IAC <verb> <option> answer on the network side
  function automatic void send_reply(input logic [7:0] verb, input logic [7:0] opt);
    emit_word(PORT_NET, C_IAC);
    emit_word(PORT_NET, verb);
    emit_word(PORT_NET, opt);
  endfunction

  // Only BINARY, ECHO and SGA are ever agreed to
  function automatic logic negotiable(input logic [7:0] opt);
    return opt == OPT_BIN || opt == OPT_ECHO || opt == OPT_SGA;
  endfunction

  // Runs one accepted network byte through the shadow parser and queues the
  // words it should produce, with last/raw/echo filled in after the step.
  function automatic void decode_net_byte(input logic [7:0] c);
    tel_word_t w;
    step_words.delete();
    case (rx_state)
      ST_IAC: begin
        rx_state = ST_DATA;
        if (c == C_BRK || c == C_IP) emit_word(PORT_TERM, raw_q ? CH_NUL : intr_c);
        else if (c == C_AYT) emit_word(PORT_TERM, CH_BEL);
        else if (c == C_EC) emit_word(PORT_TERM, erase_c);
        else if (c == C_EL) emit_word(PORT_TERM, kill_c);
        else if (c == C_SB) rx_state = ST_SUB;
        else if (c == C_WILL) rx_state = ST_WILL;
        else if (c == C_WONT) rx_state = ST_WONT;
        else if (c == C_DO) rx_state = ST_DO;
        else if (c == C_DONT) rx_state = ST_DONT;
        else if (c == C_IAC) emit_word(PORT_TERM, c);
        // anything else (NOP, DM, GA, ...) is dropped
      end
      ST_CR: begin
        // LF or NUL after CR is swallowed; anything else, IAC too, is data
        if (c != CH_NUL && c != CH_LF) emit_word(PORT_TERM, c);
        rx_state = ST_DATA;
      end
      ST_SUB: begin
        if (c == C_IAC) rx_state = ST_SUBI;
      end
      ST_SUBI: begin
        rx_state = (c == C_SE) ? ST_DATA : ST_SUB;
      end
      ST_WILL: begin
        rx_state = ST_DATA;
        if (!remote_on[c]) begin
          if (negotiable(c)) begin
            if (c == OPT_BIN) raw_q = 1'b1;
            if (c == OPT_ECHO) echo_q = 1'b0;
            remote_on[c] = 1'b1;
            send_reply(C_DO, c);
          end else begin
            send_reply(C_DONT, c);
          end
        end
      end
      ST_WONT: begin
        rx_state = ST_DATA;
        if (remote_on[c]) begin
          if (c == OPT_ECHO) echo_q = 1'b1;
          if (c == OPT_BIN) raw_q = 1'b0;
          remote_on[c] = 1'b0;
          send_reply(C_DONT, c);
        end
      end
      ST_DO: begin
        rx_state = ST_DATA;
        if (!local_on[c]) begin
          if (negotiable(c)) begin
            if (c == OPT_ECHO) echo_q = 1'b1;
            if (c == OPT_BIN) raw_q = 1'b1;
            local_on[c] = 1'b1;
            send_reply(C_WILL, c);
          end else begin
            send_reply(C_WONT, c);
          end
        end
      end
      ST_DONT: begin
        // DONT BINARY leaves raw mode alone
        rx_state = ST_DATA;
        if (local_on[c]) begin
          local_on[c] = 1'b0;
          send_reply(C_WONT, c);
        end
      end
      default: begin
        rx_state = ST_DATA;
        if (c == C_IAC) begin
          rx_state = ST_IAC;
        end else begin
          emit_word(PORT_TERM, c);
          if (!local_on[OPT_BIN] && c == CH_CR) rx_state = ST_CR;
        end
      end
    endcase
    foreach (step_words[k]) begin
      w = step_words[k];
      w.last = (k == step_words.size() - 1);
      w.raw = raw_q;
      w.echo = echo_q;
      expected_words.push_back(w);
    end
  endfunction

  // Appends one random sequence: mostly well-formed telnet traffic with random
  // content, plus some raw noise.
  function automatic void add_random_sequence();
    int kind;
    int n;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 28) begin
      net_bytes_pending.push_back(8'($urandom_range(0, 254)));
    end else if (kind < 38) begin
      // CR and whatever follows it
      net_bytes_pending.push_back(CH_CR);
      case ($urandom_range(0, 3))
        0: b = CH_LF;
        1: b = CH_NUL;
        2: b = C_IAC;
        default: b = 8'($urandom_range(0, 255));
      endcase
      net_bytes_pending.push_back(b);
    end else if (kind < 52) begin
      case ($urandom_range(0, 10))
        0: b = C_IP;
        1: b = C_BRK;
        2: b = C_AYT;
        3: b = C_EC;
        4: b = C_EL;
        5: b = CMD_NOP;
        6: b = CMD_DM;
        7: b = CMD_AO;
        8: b = CMD_GA;
        9: b = C_SE;
        default: b = C_IAC;
      endcase
      net_bytes_pending.push_back(C_IAC);
      net_bytes_pending.push_back(b);
    end else if (kind < 86) begin
      // option negotiation, weighted toward the options the block accepts
      case ($urandom_range(0, 3))
        0: b = C_WILL;
        1: b = C_WONT;
        2: b = C_DO;
        default: b = C_DONT;
      endcase
      net_bytes_pending.push_back(C_IAC);
      net_bytes_pending.push_back(b);
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 2))
          0: b = OPT_BIN;
          1: b = OPT_ECHO;
          default: b = OPT_SGA;
        endcase
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      net_bytes_pending.push_back(b);
    end else if (kind < 93) begin
      // subnegotiation, body may hold IAC followed by something other than SE
      net_bytes_pending.push_back(C_IAC);
      net_bytes_pending.push_back(C_SB);
      n = $urandom_range(0, 4);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          net_bytes_pending.push_back(C_IAC);
          net_bytes_pending.push_back(8'($urandom_range(0, 239)));
        end else begin
          net_bytes_pending.push_back(8'($urandom_range(0, 254)));
        end
      end
      net_bytes_pending.push_back(C_IAC);
      net_bytes_pending.push_back(C_SE);
    end else begin
      net_bytes_pending.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Byte driver: presents queued bytes, idles at random, and hands each
  // accepted byte to the shadow parser at the edge where it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_net_byte(in_ch.net_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (net_bytes_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.net_byte <= net_bytes_pending.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Word monitor: checks each accepted word against the oldest expectation
  // and stalls the output at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got_word.port = out_ch.out_port;
        got_word.data = out_ch.out_byte;
        got_word.last = out_ch.last_of_run;
        got_word.raw  = out_ch.raw_mode;
        got_word.echo = out_ch.echo_crmod;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word port=%0d byte=%02h",
                                    got_word.port, got_word.data));
        end else begin
          want_word = expected_words.pop_front();
          if (got_word.port !== want_word.port || got_word.data !== want_word.data ||
              got_word.last !== want_word.last || got_word.raw !== want_word.raw ||
              got_word.echo !== want_word.echo) begin
            report_mismatch($sformatf(
              "port/byte/last/raw/echo got %0d/%02h/%0d/%0d/%0d want %0d/%02h/%0d/%0d/%0d",
              got_word.port, got_word.data, got_word.last, got_word.raw, got_word.echo,
              want_word.port, want_word.data, want_word.last, want_word.raw,
              want_word.echo));
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Register write; the shadow copy follows at the accepting edge.
  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_ERASE: erase_c = value;
      CFG_KILL:  kill_c = value;
      default:   intr_c = value;
    endcase
  endtask

  // Holds the sender off until every owed word is out, then lets the clock
  // run on since a byte that makes no word may still be in flight.
  task automatic drain_results();
    int n;
    while (net_bytes_pending.size() > 0 || in_ch.valid) @(posedge clk);
    n = 0;
    while (expected_words.size() > 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    if (expected_words.size() > 0) begin
      report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
      expected_words.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  // Hard stop in case the block hangs
  initial begin
    #(CLK_PERIOD * 200000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int phase;
    int target;

    // Known values on every input from time zero
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.net_byte = '0;
    out_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = CFG_ERASE;
    cfg_ch.data = '0;

    // Shadow state matches the block after reset
    rx_state = ST_DATA;
    foreach (remote_on[i]) remote_on[i] = 1'b0;
    foreach (local_on[i]) local_on[i] = 1'b0;
    local_on[OPT_ECHO] = 1'b1;
    raw_q = 1'b0;
    echo_q = 1'b1;
    erase_c = ERASE_RST;
    kill_c = KILL_RST;
    intr_c = INTR_RST;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 4; phase++) begin
      // Idle pattern and register setting for this phase
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_reg(CFG_ERASE, 8'h00);
          write_reg(CFG_KILL, 8'hff);
          write_reg(CFG_INTR, 8'h00);
          send_idle_pct = 87;
          recv_stall_pct = 0;
        end
        2: begin
          write_reg(CFG_ERASE, 8'hff);
          write_reg(CFG_KILL, 8'h00);
          write_reg(CFG_INTR, 8'hff);
          send_idle_pct = 0;
          recv_stall_pct = 87;
        end
        default: begin
          write_reg(CFG_ERASE, 8'($urandom_range(0, 255)));
          write_reg(CFG_KILL, 8'($urandom_range(0, 255)));
          write_reg(CFG_INTR, 8'($urandom_range(0, 255)));
          send_idle_pct = 8;
          recv_stall_pct = 8;
        end
      endcase

      // Fill away from the clock edge so the driver never races the refill
      @(negedge clk);
      target = 72;
      if (phase == 0) begin
        // Directed opener at reset settings: NUL, doubled IAC, CR LF, the
        // character commands, an empty subnegotiation, then WILL ECHO and
        // DO BINARY so BREAK turns into NUL and CR LF passes untouched,
        // and DONT BINARY to leave raw mode set on its own.
        net_bytes_pending = '{CH_NUL, C_IAC, C_IAC, CH_CR, CH_LF,
                              C_IAC, C_IP, C_IAC, C_AYT, C_IAC, C_EC, C_IAC, C_EL,
                              C_IAC, C_SB, C_IAC, C_SE,
                              C_IAC, C_WILL, OPT_ECHO, C_IAC, C_DO, OPT_BIN,
                              C_IAC, C_BRK, CH_CR, CH_LF,
                              C_IAC, C_DONT, OPT_BIN};
        target = 102;
      end
      while (net_bytes_pending.size() < target) add_random_sequence();

      drain_results();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/telrx_pkg.sv
sv/telrx_if.sv
sv/telrx_decode.sv
sv/telnet_receive_negotiator_unit.sv
sv/telrx_checker.sv
test/testbench.sv
